// ===== rtl/tgarle_pkg.sv =====
// Shared types and constants for the TGA RLE image decoder.
// No dependencies. Imported by tgarle_core, tga_rle_image_decoder and tb_top.
package tgarle_pkg;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       start_of_file;
   } tgarle_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  error_code;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        has_alpha;
      logic        is_compressed;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_count;
      logic        last_of_image;
   } tgarle_rsp_type;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // header error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_DIM   = 2'd1;
   localparam logic [1:0] ERR_DEPTH = 2'd2;

   // header byte positions
   localparam logic [4:0] HDR_TYPE      = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH     = 5'd16;
   localparam logic [4:0] HDR_LAST      = 5'd17;

   localparam logic [7:0] TYPE_RAW = 8'd2;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;
   localparam logic [7:0] RUN_BIAS = 8'd127;

endpackage

// ===== rtl/tga_rle_image_decoder.sv =====
// Latency: a result appears at rsp the cycle after the byte that causes it is accepted.
// Throughput: one file byte per cycle, sustained, as long as rsp is not stalled; the
//   decode state updates in one pass per byte and a single result register sits after it.
// Reset: synchronous, active high; the decoder goes idle and ignores bytes until a
//   byte flagged start_of_file, and the result register empties.
// Top level of the TGA RLE image decoder; depends on tgarle_pkg and tgarle_core.
module tga_rle_image_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tgarle_pkg::tgarle_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tgarle_pkg::tgarle_rsp_type rsp_data
);
   import tgarle_pkg::*;

   logic           req_accept;
   logic           core_valid;
   tgarle_rsp_type core_data;
   logic           rsp_valid_ff;
   tgarle_rsp_type rsp_data_ff;

   // Hold off new requests only while a result sits in the output register and
   // the consumer is stalling; otherwise the register is free or draining now.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // Header parse, packet decode and pixel assembly for one byte.
   tgarle_core u_core (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_accept),
      .byte_data  (req_data),
      .res_valid  (core_valid),
      .res_data   (core_data)
   );

   // Output register: load on an accepted request, drop when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= core_valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload needs no reset; hold it unless a new result arrives.
   always_ff @(posedge clock) begin
      if (req_accept && core_valid) begin
         rsp_data_ff <= core_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A stall toward the source only ever comes from a full, stalled output.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a pending result");

   // A pixel result always covers at least one pixel.
   a_pixel_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_PIXEL) |-> (rsp_data.repeat_count != 8'd0))
      else $error("pixel result with zero repeat count");

   // An error result carries a nonzero code and no pixel payload.
   a_error_code : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_ERROR) |->
         (rsp_data.error_code != ERR_NONE && rsp_data.repeat_count == 8'd0))
      else $error("header error result malformed");

   // A result accepted under no stall with no new request leaves the register empty.
   a_drain : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !req_valid) |=> !rsp_valid)
      else $error("result delivered twice");

   // Reset empties the output register.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

// ===== rtl/tgarle_core.sv =====
// Header parse and RLE packet decode state for the TGA RLE image decoder.
// Depends on tgarle_pkg. One byte per accepted request, result is combinational.
module tgarle_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       byte_valid,
   input  tgarle_pkg::tgarle_req_type byte_data,
   output logic                       res_valid,
   output tgarle_pkg::tgarle_rsp_type res_data
);
   import tgarle_pkg::*;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_HEADER  = 3'd1;
   localparam logic [2:0] PH_HEAD    = 3'd2;
   localparam logic [2:0] PH_LITERAL = 3'd3;
   localparam logic [2:0] PH_RUN     = 3'd4;
   localparam logic [2:0] PH_DONE    = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  hdr_idx_ff, hdr_idx_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  depth_ff, depth_in;
   logic        four_ff, four_in;
   logic [7:0]  pkt_rem_ff, pkt_rem_in;
   logic [1:0]  byte_pos_ff, byte_pos_in;
   logic [7:0]  blue_ff, blue_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  red_ff, red_in;
   logic [31:0] pix_rem_ff, pix_rem_in;

   logic [7:0]  b;
   logic        sof;
   logic [2:0]  ph;
   logic [31:0] area;
   logic [1:0]  last_pos;
   logic [7:0]  rep_raw;
   logic [7:0]  rep;
   logic [31:0] pix_left;
   logic [7:0]  pkt_dec;

   assign b        = byte_data.file_byte;
   assign sof      = byte_data.start_of_file;
   assign area     = {16'd0, width_ff} * {16'd0, height_ff};
   assign last_pos = four_ff ? 2'd3 : 2'd2;

   always_comb begin
      // start of file clears the decode state (not the pixel bytes) and restarts the header
      ph          = sof ? PH_HEADER : phase_ff;
      phase_in    = ph;
      hdr_idx_in  = sof ? 5'd0 : hdr_idx_ff;
      type_in     = sof ? 8'd0 : type_ff;
      width_in    = sof ? 16'd0 : width_ff;
      height_in   = sof ? 16'd0 : height_ff;
      depth_in    = sof ? 8'd0 : depth_ff;
      four_in     = sof ? 1'b0 : four_ff;
      pkt_rem_in  = sof ? 8'd0 : pkt_rem_ff;
      byte_pos_in = sof ? 2'd0 : byte_pos_ff;
      pix_rem_in  = sof ? 32'd0 : pix_rem_ff;
      blue_in     = blue_ff;
      green_in    = green_ff;
      red_in      = red_ff;
      rep_raw     = 8'd1;
      rep         = 8'd1;
      pix_left    = pix_rem_ff;
      pkt_dec     = pkt_rem_ff;
      res_valid   = 1'b0;
      res_data    = '0;
      res_data.is_compressed = (type_in != TYPE_RAW);

      unique case (ph)
         PH_HEADER: begin
            case (hdr_idx_in)
               HDR_TYPE:      type_in          = b;
               HDR_WIDTH_LO:  width_in[7:0]    = b;
               HDR_WIDTH_HI:  width_in[15:8]   = b;
               HDR_HEIGHT_LO: height_in[7:0]   = b;
               HDR_HEIGHT_HI: height_in[15:8]  = b;
               HDR_DEPTH:     depth_in         = b;
               default: ;
            endcase
            if (hdr_idx_in != HDR_LAST) begin
               hdr_idx_in = hdr_idx_in + 5'd1;
            end else begin
               res_valid              = 1'b1;
               res_data.image_width   = width_ff;
               res_data.image_height  = height_ff;
               if (width_ff == 16'd0 || height_ff == 16'd0) begin
                  res_data.kind       = KIND_ERROR;
                  res_data.error_code = ERR_DIM;
                  phase_in            = PH_IDLE;
               end else if (depth_ff != DEPTH_24 && depth_ff != DEPTH_32) begin
                  res_data.kind       = KIND_ERROR;
                  res_data.error_code = ERR_DEPTH;
                  phase_in            = PH_IDLE;
               end else begin
                  four_in             = (depth_ff == DEPTH_32);
                  pix_rem_in          = area;
                  byte_pos_in         = 2'd0;
                  phase_in            = (type_ff != TYPE_RAW) ? PH_HEAD : PH_LITERAL;
                  res_data.kind       = KIND_HEADER;
                  res_data.has_alpha  = (depth_ff == DEPTH_32);
               end
            end
         end
         PH_HEAD: begin
            if (b[7]) begin
               pkt_rem_in = b - RUN_BIAS;
               phase_in   = PH_RUN;
            end else begin
               pkt_rem_in = b + 8'd1;
               phase_in   = PH_LITERAL;
            end
            byte_pos_in = 2'd0;
         end
         PH_LITERAL, PH_RUN: begin
            if (byte_pos_ff != last_pos) begin
               case (byte_pos_ff)
                  2'd0:    blue_in  = b;
                  2'd1:    green_in = b;
                  2'd2:    red_in   = b;
                  default: ;
               endcase
               byte_pos_in = byte_pos_ff + 2'd1;
            end else begin
               byte_pos_in = 2'd0;
               rep_raw     = (ph == PH_RUN) ? pkt_rem_ff : 8'd1;
               // clip the run to what is left of the image
               rep         = ({24'd0, rep_raw} > pix_rem_ff) ? pix_rem_ff[7:0] : rep_raw;
               pix_left    = pix_rem_ff - {24'd0, rep};
               pix_rem_in  = pix_left;

               res_valid             = 1'b1;
               res_data.kind         = KIND_PIXEL;
               res_data.has_alpha    = four_ff;
               res_data.red          = four_ff ? red_ff : b;
               res_data.green        = green_ff;
               res_data.blue         = blue_ff;
               res_data.alpha        = four_ff ? b : 8'd0;
               res_data.repeat_count = rep;

               if (type_ff != TYPE_RAW) begin
                  if (ph == PH_RUN) begin
                     pkt_rem_in = 8'd0;
                     phase_in   = PH_HEAD;
                  end else begin
                     pkt_dec    = (pkt_rem_ff != 8'd0) ? pkt_rem_ff - 8'd1 : pkt_rem_ff;
                     pkt_rem_in = pkt_dec;
                     if (pkt_dec == 8'd0) begin
                        phase_in = PH_HEAD;
                     end
                  end
               end
               if (pix_left == 32'd0) begin
                  phase_in               = PH_DONE;
                  res_data.last_of_image = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         hdr_idx_ff  <= 5'd0;
         type_ff     <= 8'd0;
         width_ff    <= 16'd0;
         height_ff   <= 16'd0;
         depth_ff    <= 8'd0;
         four_ff     <= 1'b0;
         pkt_rem_ff  <= 8'd0;
         byte_pos_ff <= 2'd0;
         pix_rem_ff  <= 32'd0;
      end else if (byte_valid) begin
         phase_ff    <= phase_in;
         hdr_idx_ff  <= hdr_idx_in;
         type_ff     <= type_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         depth_ff    <= depth_in;
         four_ff     <= four_in;
         pkt_rem_ff  <= pkt_rem_in;
         byte_pos_ff <= byte_pos_in;
         pix_rem_ff  <= pix_rem_in;
      end
   end

   // pixel bytes are payload, no reset
   always_ff @(posedge clock) begin
      if (byte_valid) begin
         blue_ff  <= blue_in;
         green_ff <= green_in;
         red_ff   <= red_in;
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for tga_rle_image_decoder: byte-stream TGA files in, pixel runs out.
// Uses tgarle_pkg for the request and result structs and the header and code constants.
// An in-bench decoder predicts every result; a checker compares them field by field.
module tb_top;
   import tgarle_pkg::*;

   localparam int CLOCK_HALF     = 10;
   localparam int TOTAL_BYTES    = 1550;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 1500;
   localparam int SETTLE_CYCLES  = 8;

   // decoder phases of the in-bench prediction
   typedef enum logic [2:0] {
      PH_IDLE, PH_HEADER, PH_HEAD, PH_LITERAL, PH_RUN, PH_DONE
   } decode_phase_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   tgarle_req_type req_data = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   tgarle_rsp_type rsp_data;

   // results predicted but not yet seen on rsp, oldest first
   tgarle_rsp_type decoded_queue[$];
   int             mismatch_count = 0;
   int unsigned    bytes_sent = 0;
   int unsigned    idle_cycles = 0;
   bit             send_gaps = 1'b1;
   logic           recv_gaps = 1'b1;
   logic           rsp_hold = 1'b0;
   int             stall_left = 0;
   int             stall_draw;

   // predicted decoder state, reset values as declared
   decode_phase_type ph = PH_IDLE;
   logic [4:0]     hdr_index = '0;
   logic [7:0]     img_type = '0;
   logic [15:0]    img_w = '0;
   logic [15:0]    img_h = '0;
   logic [7:0]     img_depth = '0;
   logic           alpha_px = 1'b0;
   logic [7:0]     pkt_left = '0;
   logic [1:0]     byte_pos = '0;
   logic [31:0]    assembly = '0;
   logic [31:0]    px_left = '0;

   tga_rle_image_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // Advance the predicted decoder by one accepted byte; queue the result it causes, if any.
   task automatic decode_byte(input logic [7:0] b, input logic sof);
      tgarle_rsp_type r;
      logic [1:0]     last_pos;
      logic [31:0]    reps;
      r = '0;
      if (sof) begin
         hdr_index = '0;
         img_type  = '0;
         img_w     = '0;
         img_h     = '0;
         img_depth = '0;
         alpha_px  = 1'b0;
         pkt_left  = '0;
         byte_pos  = '0;
         assembly  = '0;
         px_left   = '0;
         ph        = PH_HEADER;
      end
      // idle and finished images swallow bytes silently
      if (ph == PH_IDLE || ph == PH_DONE)
         return;

      if (ph == PH_HEADER) begin
         case (hdr_index)
            HDR_TYPE:      img_type = b;
            HDR_WIDTH_LO:  img_w[7:0] = b;
            HDR_WIDTH_HI:  img_w[15:8] = b;
            HDR_HEIGHT_LO: img_h[7:0] = b;
            HDR_HEIGHT_HI: img_h[15:8] = b;
            HDR_DEPTH:     img_depth = b;
            default: ;
         endcase
         if (hdr_index < HDR_LAST) begin
            hdr_index++;
            return;
         end
         r.image_width  = img_w;
         r.image_height = img_h;
         // a zero dimension wins over a bad depth
         if (img_w == '0 || img_h == '0) begin
            r.kind       = KIND_ERROR;
            r.error_code = ERR_DIM;
            ph           = PH_IDLE;
         end else if (img_depth != DEPTH_24 && img_depth != DEPTH_32) begin
            r.kind       = KIND_ERROR;
            r.error_code = ERR_DEPTH;
            ph           = PH_IDLE;
         end else begin
            alpha_px    = (img_depth == DEPTH_32);
            px_left     = {16'd0, img_w} * {16'd0, img_h};
            byte_pos    = '0;
            assembly    = '0;
            ph          = (img_type != TYPE_RAW) ? PH_HEAD : PH_LITERAL;
            r.kind      = KIND_HEADER;
            r.has_alpha = alpha_px;
         end
      end else if (ph == PH_HEAD) begin
         // bit 7 set: one pixel repeated head - 127 times; else head + 1 literal pixels
         if (b[7]) begin
            pkt_left = b - RUN_BIAS;
            ph       = PH_RUN;
         end else begin
            pkt_left = b + 8'd1;
            ph       = PH_LITERAL;
         end
         byte_pos = '0;
         assembly = '0;
         return;
      end else begin
         last_pos = alpha_px ? 2'd3 : 2'd2;
         assembly[8 * byte_pos +: 8] = b;
         if (byte_pos != last_pos) begin
            byte_pos++;
            return;
         end
         byte_pos = '0;
         // clip the run to what the image still needs
         reps = (ph == PH_RUN) ? {24'd0, pkt_left} : 32'd1;
         if (reps > px_left)
            reps = px_left;
         px_left        = px_left - reps;
         r.kind         = KIND_PIXEL;
         r.has_alpha    = alpha_px;
         r.red          = assembly[23:16];
         r.green        = assembly[15:8];
         r.blue         = assembly[7:0];
         r.alpha        = alpha_px ? assembly[31:24] : 8'd0;
         r.repeat_count = reps[7:0];
         assembly       = '0;
         if (img_type != TYPE_RAW) begin
            if (ph == PH_RUN) begin
               pkt_left = '0;
               ph       = PH_HEAD;
            end else begin
               if (pkt_left != '0)
                  pkt_left--;
               if (pkt_left == '0)
                  ph = PH_HEAD;
            end
         end
         if (px_left == '0) begin
            ph              = PH_DONE;
            r.last_of_image = 1'b1;
         end
      end
      r.is_compressed = (img_type != TYPE_RAW);
      decoded_queue = {decoded_queue, r};
   endtask

   // Offer one byte after a random gap, hold it until accepted, then predict.
   task automatic send_byte(input logic [7:0] b, input logic sof);
      int gap;
      gap = send_gaps ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{file_byte: b, start_of_file: sof};
      do @(posedge clock); while (req_stall);
      decode_byte(b, sof);
      bytes_sent++;
   endtask

   // Drop valid and hold until every predicted result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (decoded_queue.size() != 0);
   endtask

   // Send the 18 header bytes; fields not decoded carry random filler.
   task automatic send_header(input logic [7:0] kind_byte, input logic [15:0] w,
                              input logic [15:0] h, input logic [7:0] depth);
      logic [7:0] b;
      for (int i = 0; i <= HDR_LAST; i++) begin
         case (5'(i))
            HDR_TYPE:      b = kind_byte;
            HDR_WIDTH_LO:  b = w[7:0];
            HDR_WIDTH_HI:  b = w[15:8];
            HDR_HEIGHT_LO: b = h[7:0];
            HDR_HEIGHT_HI: b = h[15:8];
            HDR_DEPTH:     b = depth;
            default:       b = 8'($urandom);
         endcase
         send_byte(b, i == 0);
      end
   endtask

   task automatic send_pixel(input logic alpha);
      repeat (alpha ? 4 : 3) send_byte(8'($urandom), 1'b0);
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(8'($urandom), 1'b0);
   endtask

   // One random file: mostly well-formed, some broken headers, cut or overlong bodies.
   task automatic send_random_file();
      logic [7:0]  kind_byte;
      logic [7:0]  depth;
      logic [15:0] w;
      logic [15:0] h;
      logic        alpha;
      int          sel;
      int          left;
      int          n;
      sel = $urandom_range(0, 99);
      if (sel < 45)
         kind_byte = TYPE_RAW;
      else if (sel < 90)
         kind_byte = 8'd10;
      else
         kind_byte = 8'($urandom);
      w = ($urandom_range(0, 24) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      h = ($urandom_range(0, 24) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      sel = $urandom_range(0, 19);
      if (sel < 9)
         depth = DEPTH_24;
      else if (sel < 18)
         depth = DEPTH_32;
      else
         depth = 8'($urandom);
      send_header(kind_byte, w, h, depth);
      if (w == '0 || h == '0 || (depth != DEPTH_24 && depth != DEPTH_32)) begin
         send_noise($urandom_range(0, 4));
         return;
      end
      alpha = (depth == DEPTH_32);
      left  = int'(w) * int'(h);
      sel   = $urandom_range(0, 9);
      if (sel == 0)
         left = $urandom_range(0, left - 1);   // abandoned by the next file start
      else if (sel == 1)
         left += $urandom_range(1, 8);         // pixels past the end of the image
      if (kind_byte == TYPE_RAW) begin
         repeat (left) send_pixel(alpha);
      end else begin
         while (left > 0) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
            if ($urandom_range(0, 1) == 1) begin
               send_byte(8'(RUN_BIAS + n), 1'b0);
               send_pixel(alpha);
            end else begin
               if (n > 16)
                  n = n % 16 + 1;
               send_byte(8'(n - 1), 1'b0);
               repeat (n) send_pixel(alpha);
            end
            left -= n;
         end
      end
      if ($urandom_range(0, 7) == 0)
         send_noise($urandom_range(1, 3));
   endtask

   task automatic test_bytes_before_file();
      send_noise(3);
      wait_drained();
   endtask

   task automatic test_header_errors();
      send_header(8'd10, 16'd0, 16'd5, DEPTH_24);
      send_noise(2);
      send_header(TYPE_RAW, 16'd3, 16'd0, DEPTH_32);
      // both checks fail: the dimension error is the one reported
      send_header(8'd0, 16'd0, 16'd0, 8'd8);
      send_header(TYPE_RAW, 16'd1, 16'd1, 8'd16);
      send_noise(2);
      send_header(8'hFF, 16'd1, 16'd1, 8'hFF);
      wait_drained();
   endtask

   task automatic test_raw_images();
      send_header(TYPE_RAW, 16'd2, 16'd1, DEPTH_24);
      repeat (3) send_byte(8'h00, 1'b0);
      repeat (3) send_byte(8'hFF, 1'b0);
      // image complete: these are ignored
      send_noise(2);
      send_header(TYPE_RAW, 16'd1, 16'd1, DEPTH_32);
      send_pixel(1'b1);
      wait_drained();
   endtask

   task automatic test_rle_packets();
      send_header(8'd10, 16'd4, 16'd2, DEPTH_32);
      send_byte(8'h00, 1'b0);                 // literal of one pixel
      send_pixel(1'b1);
      send_byte(8'h80, 1'b0);                 // shortest run
      send_pixel(1'b1);
      send_byte(8'h81, 1'b0);
      send_pixel(1'b1);
      // longest literal packet, cut short by the end of the image
      send_byte(8'h7F, 1'b0);
      repeat (5) send_pixel(1'b1);
      // longest run against three pixels left: clipped
      send_header(8'd9, 16'd3, 16'd1, DEPTH_24);
      send_byte(8'hFF, 1'b0);
      send_pixel(1'b0);
      send_noise(2);
      wait_drained();
   endtask

   task automatic test_extremes_and_abandon();
      send_header(8'hFF, 16'hFFFF, 16'hFFFF, DEPTH_32);
      send_byte(8'hFF, 1'b0);
      repeat (4) send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      repeat (4) send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b0);
      // a new file start in mid-image drops the old one
      send_header(8'd0, 16'h0100, 16'h0001, DEPTH_24);
      send_byte(8'hAA, 1'b0);
      send_pixel(1'b0);
      send_header(TYPE_RAW, 16'd1, 16'd1, DEPTH_24);
      send_pixel(1'b0);
      wait_drained();
   endtask

   // Hold rsp off for a long stretch while bytes keep coming, so the decoder backs up.
   task automatic test_backpressure();
      send_gaps = 1'b0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      send_header(TYPE_RAW, 16'd4, 16'd4, DEPTH_24);
      repeat (16) send_pixel(1'b0);
      wait_drained();
      send_gaps = 1'b1;
   endtask

   task automatic test_full_rate();
      send_gaps = 1'b0;
      recv_gaps <= 1'b0;
      repeat (4) send_random_file();
      wait_drained();
      recv_gaps <= 1'b1;
      send_gaps = 1'b1;
   endtask

   // Random files until the whole run has sent its share of bytes.
   task automatic test_random_files();
      while (bytes_sent < TOTAL_BYTES)
         send_random_file();
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bytes_before_file();
      test_header_errors();
      test_raw_images();
      test_rle_packets();
      test_extremes_and_abandon();
      test_backpressure();
      test_full_rate();
      test_random_files();
      // let any stray result show up before judging
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Receiver: while recv_gaps is set, stall rsp for a random draw after each accepted result; honor the long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_hold) begin
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (rsp_valid && !rsp_stall && recv_gaps) begin
         stall_draw = $urandom_range(0, 3);
         rsp_stall  <= (stall_draw != 0);
         stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h", field, got, want);
      mismatch_count++;
   endtask

   task automatic compare_result(input tgarle_rsp_type got, input tgarle_rsp_type want);
      if (got.kind !== want.kind)
         report_mismatch("kind", 32'(got.kind), 32'(want.kind));
      if (got.error_code !== want.error_code)
         report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
      if (got.image_width !== want.image_width)
         report_mismatch("image_width", 32'(got.image_width), 32'(want.image_width));
      if (got.image_height !== want.image_height)
         report_mismatch("image_height", 32'(got.image_height), 32'(want.image_height));
      if (got.has_alpha !== want.has_alpha)
         report_mismatch("has_alpha", 32'(got.has_alpha), 32'(want.has_alpha));
      if (got.is_compressed !== want.is_compressed)
         report_mismatch("is_compressed", 32'(got.is_compressed), 32'(want.is_compressed));
      if (got.red !== want.red)
         report_mismatch("red", 32'(got.red), 32'(want.red));
      if (got.green !== want.green)
         report_mismatch("green", 32'(got.green), 32'(want.green));
      if (got.blue !== want.blue)
         report_mismatch("blue", 32'(got.blue), 32'(want.blue));
      if (got.alpha !== want.alpha)
         report_mismatch("alpha", 32'(got.alpha), 32'(want.alpha));
      if (got.repeat_count !== want.repeat_count)
         report_mismatch("repeat_count", 32'(got.repeat_count), 32'(want.repeat_count));
      if (got.last_of_image !== want.last_of_image)
         report_mismatch("last_of_image", 32'(got.last_of_image), 32'(want.last_of_image));
   endtask

   // Checker: match each accepted result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decoded_queue.size() == 0)
            report_mismatch("result with none expected", 32'(rsp_data.kind), 32'd0);
         else
            compare_result(rsp_data, decoded_queue.pop_front());
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
